// ===== rtl/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// Word layouts of both channels, command and segment codes, register map.
// No dependencies.
`default_nettype none

package i2cmbe_pkg;

  localparam int DELAY_BITS_DEF = 10;
  localparam int BYTE_BITS      = 8;
  localparam int CFG_IDX_BITS   = 3;

  typedef struct packed {
    logic                 cmd_valid;
    logic [1:0]           action;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 master_nack;
    logic                 sda_in;
  } in_word_t;

  typedef struct packed {
    logic                 scl_out;
    logic                 sda_out;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 slave_nack;
  } out_word_t;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SETUP     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_TAIL  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_READ_HIGH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD      = 3'd4;

  localparam int SETUP_RESET     = 10;
  localparam int HIGH_RESET      = 50;
  localparam int LOW_TAIL_RESET  = 30;
  localparam int READ_HIGH_RESET = 40;
  localparam int HOLD_RESET      = 100;

  typedef enum logic [2:0] {
    SEG_SETUP,
    SEG_HIGH,
    SEG_LOW_TAIL,
    SEG_READ_HIGH,
    SEG_HOLD
  } seg_sel_t;

endpackage

`default_nettype wire

// ===== rtl/i2cmbe_cfg.sv =====
// Timing register file of the I2C master byte engine.
// Holds the five tick counts and returns the length of the selected segment.
// Depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_cfg #(
  parameter int DELAY_BITS = i2cmbe_pkg::DELAY_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [i2cmbe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [DELAY_BITS-1:0]               cfg_data,
  input  wire i2cmbe_pkg::seg_sel_t                seg_sel,
  output logic      [DELAY_BITS-1:0]               seg_len
);
  import i2cmbe_pkg::*;

  logic [DELAY_BITS-1:0] setup_ticks;
  logic [DELAY_BITS-1:0] high_ticks;
  logic [DELAY_BITS-1:0] low_tail_ticks;
  logic [DELAY_BITS-1:0] read_high_ticks;
  logic [DELAY_BITS-1:0] hold_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_ticks     <= DELAY_BITS'(SETUP_RESET);
      high_ticks      <= DELAY_BITS'(HIGH_RESET);
      low_tail_ticks  <= DELAY_BITS'(LOW_TAIL_RESET);
      read_high_ticks <= DELAY_BITS'(READ_HIGH_RESET);
      hold_ticks      <= DELAY_BITS'(HOLD_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SETUP:     setup_ticks     <= cfg_data;
        CFG_HIGH:      high_ticks      <= cfg_data;
        CFG_LOW_TAIL:  low_tail_ticks  <= cfg_data;
        CFG_READ_HIGH: read_high_ticks <= cfg_data;
        CFG_HOLD:      hold_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (seg_sel)
      SEG_SETUP:     seg_len = setup_ticks;
      SEG_HIGH:      seg_len = high_ticks;
      SEG_LOW_TAIL:  seg_len = low_tail_ticks;
      SEG_READ_HIGH: seg_len = read_high_ticks;
      default:       seg_len = hold_ticks;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/i2cmbe_core.sv =====
// Bus sequencer of the I2C master byte engine: phase, tick and bit counters,
// shift register, pin levels and result flags, advanced once per tick word.
// Depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_core #(
  parameter int DELAY_BITS = i2cmbe_pkg::DELAY_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire i2cmbe_pkg::in_word_t    item,
  output i2cmbe_pkg::seg_sel_t         seg_sel,
  input  wire logic [DELAY_BITS-1:0]   seg_len,
  output i2cmbe_pkg::out_word_t        res
);
  import i2cmbe_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_PRE, PH_ST_LOW, PH_ST_HOLD, PH_SP_PRE, PH_SP_HIGH, PH_SP_HOLD,
    PH_WR_SET, PH_WR_HIGH, PH_WR_LOW, PH_WR_ACK1, PH_WR_ACK2, PH_WR_HOLD,
    PH_RD_HIGH, PH_RD_LOW, PH_RD_ACKSET, PH_RD_ACKHIGH, PH_RD_HOLD
  } phase_t;

  function automatic logic [1:0] levels(phase_t ph, logic b, logic ack, logic [1:0] keep);
    logic [1:0] lv;
    case (ph)
      PH_ST_PRE:     lv = 2'b11;
      PH_ST_LOW:     lv = 2'b10;
      PH_ST_HOLD:    lv = 2'b00;
      PH_SP_PRE:     lv = 2'b00;
      PH_SP_HIGH:    lv = 2'b10;
      PH_SP_HOLD:    lv = 2'b11;
      PH_WR_SET:     lv = {1'b0, b};
      PH_WR_HIGH:    lv = {1'b1, b};
      PH_WR_LOW:     lv = {1'b0, b};
      PH_WR_ACK1:    lv = 2'b11;
      PH_WR_ACK2:    lv = 2'b11;
      PH_WR_HOLD:    lv = 2'b01;
      PH_RD_HIGH:    lv = 2'b11;
      PH_RD_LOW:     lv = 2'b01;
      PH_RD_ACKSET:  lv = {1'b0, ack};
      PH_RD_ACKHIGH: lv = {1'b1, ack};
      PH_RD_HOLD:    lv = 2'b01;
      default:       lv = keep;
    endcase
    return lv;
  endfunction

  function automatic seg_sel_t seg_of(phase_t ph);
    seg_sel_t s;
    case (ph)
      PH_ST_PRE, PH_SP_PRE, PH_WR_SET, PH_WR_ACK1,
      PH_WR_ACK2, PH_RD_LOW, PH_RD_ACKSET:  s = SEG_SETUP;
      PH_WR_HIGH, PH_RD_ACKHIGH:            s = SEG_HIGH;
      PH_WR_LOW:                            s = SEG_LOW_TAIL;
      PH_RD_HIGH:                           s = SEG_READ_HIGH;
      default:                              s = SEG_HOLD;
    endcase
    return s;
  endfunction

  phase_t                phase;
  logic [DELAY_BITS-1:0] tick_count;
  logic [3:0]            bit_count;
  logic [BYTE_BITS-1:0]  shift_reg;
  logic                  ack_to_send;
  logic [1:0]            pins;
  logic [BYTE_BITS-1:0]  received_byte;
  logic                  nack_flag;

  phase_t                ph_a;
  logic [DELAY_BITS-1:0] tick_a;
  logic [3:0]            bit_a;
  logic [BYTE_BITS-1:0]  shift_a;
  logic                  ack_a;
  logic [1:0]            pins_a;

  phase_t                phase_next;
  logic [DELAY_BITS-1:0] tick_count_next;
  logic [DELAY_BITS-1:0] tick_inc;
  logic [3:0]            bit_count_next;
  logic [3:0]            bit_inc;
  logic [BYTE_BITS-1:0]  shift_reg_next;
  logic [1:0]            pins_next;
  logic [BYTE_BITS-1:0]  received_byte_next;
  logic                  nack_flag_next;
  logic                  done;

  always_comb begin
    ph_a    = phase;
    tick_a  = tick_count;
    bit_a   = bit_count;
    shift_a = shift_reg;
    ack_a   = ack_to_send;
    if (phase == PH_IDLE && item.cmd_valid) begin
      ack_a  = item.master_nack;
      tick_a = '0;
      bit_a  = '0;
      case (item.action)
        ACT_START: ph_a = PH_ST_PRE;
        ACT_STOP:  ph_a = PH_SP_PRE;
        ACT_WRITE: begin
          shift_a = item.tx_byte;
          ph_a    = PH_WR_SET;
        end
        default: begin
          shift_a = '0;
          ph_a    = PH_RD_HIGH;
        end
      endcase
    end
    pins_a = levels(ph_a, shift_a[BYTE_BITS-1], ack_a, pins);
  end

  assign seg_sel = seg_of(ph_a);

  always_comb begin
    phase_next         = ph_a;
    tick_count_next    = tick_a;
    bit_count_next     = bit_a;
    shift_reg_next     = shift_a;
    pins_next          = pins_a;
    received_byte_next = received_byte;
    nack_flag_next     = nack_flag;
    done               = 1'b0;
    tick_inc           = tick_a + 1'b1;
    bit_inc            = bit_a + 1'b1;
    if (ph_a != PH_IDLE) begin
      tick_count_next = tick_inc;
      if (tick_inc >= seg_len) begin
        tick_count_next = '0;
        case (ph_a)
          PH_ST_PRE:  phase_next = PH_ST_LOW;
          PH_ST_LOW:  phase_next = PH_ST_HOLD;
          PH_SP_PRE:  phase_next = PH_SP_HIGH;
          PH_SP_HIGH: phase_next = PH_SP_HOLD;
          PH_WR_SET:  phase_next = PH_WR_HIGH;
          PH_WR_HIGH: phase_next = PH_WR_LOW;
          PH_WR_LOW: begin
            shift_reg_next = {shift_a[BYTE_BITS-2:0], 1'b0};
            bit_count_next = bit_inc;
            phase_next     = (bit_inc >= 4'(BYTE_BITS)) ? PH_WR_ACK1 : PH_WR_SET;
          end
          PH_WR_ACK1: begin
            nack_flag_next = item.sda_in;
            phase_next     = PH_WR_ACK2;
          end
          PH_WR_ACK2: phase_next = PH_WR_HOLD;
          PH_RD_HIGH: begin
            shift_reg_next = {shift_a[BYTE_BITS-2:0], item.sda_in};
            bit_count_next = bit_inc;
            if (bit_inc >= 4'(BYTE_BITS)) begin
              received_byte_next = {shift_a[BYTE_BITS-2:0], item.sda_in};
            end
            phase_next = PH_RD_LOW;
          end
          PH_RD_LOW:     phase_next = (bit_a >= 4'(BYTE_BITS)) ? PH_RD_ACKSET : PH_RD_HIGH;
          PH_RD_ACKSET:  phase_next = PH_RD_ACKHIGH;
          PH_RD_ACKHIGH: phase_next = PH_RD_HOLD;
          default:       phase_next = PH_IDLE;
        endcase
        if (phase_next == PH_IDLE) begin
          done = 1'b1;
        end else begin
          pins_next = levels(phase_next, shift_reg_next[BYTE_BITS-1], ack_a, pins_a);
        end
      end
    end
  end

  always_comb begin
    res.scl_out    = pins_a[1];
    res.sda_out    = pins_a[0];
    res.busy_res   = (ph_a != PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = received_byte_next;
    res.slave_nack = nack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_count     <= '0;
      shift_reg     <= '0;
      ack_to_send   <= 1'b0;
      pins          <= 2'b11;
      received_byte <= '0;
      nack_flag     <= 1'b0;
    end else if (en) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      ack_to_send   <= ack_a;
      pins          <= pins_next;
      received_byte <= received_byte_next;
      nack_flag     <= nack_flag_next;
    end
  end

  a_bit_count_bound: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'(BYTE_BITS))
    else $error("bit counter past one byte");

  a_idle_tick_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0)
    else $error("tick counter not cleared while idle");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    en && done |=> phase == PH_IDLE)
    else $error("command finished but sequencer not idle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ph_a != PH_IDLE)
    else $error("finish flagged without a running command");

endmodule

`default_nettype wire

// ===== rtl/i2c_master_byte_engine_top.sv =====
// I2C master byte engine, top level: input word register, bus sequencer,
// timing registers and result word register.
// Depends on i2cmbe_pkg, i2cmbe_cfg and i2cmbe_core.
//
// Usage:
//   Each input word is one time tick. It carries an optional command
//   (start, stop, write byte, read byte) and the sampled SDA level. A command
//   is taken only when no command is running; otherwise its fields are ignored.
//   Each tick word yields exactly one result word: the SCL and SDA levels
//   driven during that tick, busy and done flags, the last received byte and
//   the last sampled slave acknowledge.
//   An accepted word waits in the input register, then the sequencer step
//   loads the result register. Throughput is one word per cycle while
//   out_stall is low; the sequencer computes its next state combinationally.
//   When out_stall is high the result word holds, the input register fills,
//   and in_stall rises until the result is taken.
//   Timing registers are written through cfg_wr_en/cfg_index/cfg_data; the
//   user must write them only while the engine is idle, which the block
//   does not enforce. Reset clears the sequencer to idle with both lines
//   released and loads the default tick counts.
`default_nettype none

module i2c_master_byte_engine_top #(
  parameter int DELAY_BITS = i2cmbe_pkg::DELAY_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire i2cmbe_pkg::in_word_t                in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output i2cmbe_pkg::out_word_t                    out_data,
  input  wire logic                                cfg_wr_en,
  input  wire logic [i2cmbe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [DELAY_BITS-1:0]               cfg_data
);
  import i2cmbe_pkg::*;

  logic                  s1_valid;
  in_word_t              s1_word;
  logic                  s2_ready;
  logic                  fire;
  seg_sel_t              seg_sel;
  logic [DELAY_BITS-1:0] seg_len;
  out_word_t             core_res;

  assign s2_ready = !out_valid || !out_stall;
  assign fire     = s1_valid && s2_ready;
  assign in_stall = s1_valid && !s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= core_res;
    end
  end

  i2cmbe_cfg #(
    .DELAY_BITS (DELAY_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seg_sel   (seg_sel),
    .seg_len   (seg_len)
  );

  i2cmbe_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (fire),
    .item    (s1_word),
    .seg_sel (seg_sel),
    .seg_len (seg_len),
    .res     (core_res)
  );

  a_fire_loads_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result word lost after sequencer step");

  a_done_has_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done word without busy");

  a_stall_keeps_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_word))
    else $error("pending tick word dropped under stall");

endmodule

`default_nettype wire
